FILE: design/rkacw_pkg.sv
// Shared types, constants and AES round functions for the reduced-key AES chain walker.
// Depends on nothing; every design file but rkacw_fifo imports it.
package rkacw_pkg;

    // One AES block or round key, byte i in element i.
    typedef logic [15:0][7:0] rkacw_blk_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_PT_WORD0 = 3'd0;
    localparam logic [2:0] REG_PT_WORD1 = 3'd1;
    localparam logic [2:0] REG_PT_WORD2 = 3'd2;
    localparam logic [2:0] REG_PT_WORD3 = 3'd3;
    localparam logic [2:0] REG_CHAIN_LEN = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] PT_WORD0_RST = 32'hf33ccd08;
    localparam logic [31:0] PT_WORD1_RST = 32'h44c65df2;
    localparam logic [31:0] PT_WORD2_RST = 32'h8127c373;
    localparam logic [31:0] PT_WORD3_RST = 32'hecbafbe6;
    localparam logic [10:0] CHAIN_LEN_RST = 11'd32;

    // Pipeline geometry and queue depths.
    localparam int NUM_ROUNDS = 10;
    localparam int IN_DEPTH = 4;
    localparam int OUT_DEPTH = 16;
    localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic        vld;
        logic [23:0] start;
        logic [7:0]  tbl;
        logic [10:0] steps;
    } rkacw_item_t;

    // Status of the back part, watched by the checks in the top level.
    typedef struct packed {
        logic                retire;
        logic                bypass;
        logic [CREDIT_W-1:0] credit;
    } rkacw_status_t;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8).
    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Next AES-128 round key.
    function automatic rkacw_blk_t next_key(input rkacw_blk_t k, input logic [7:0] rc);
        rkacw_blk_t n;
        n[0] = k[0] ^ SBOX[k[13]] ^ rc;
        n[1] = k[1] ^ SBOX[k[14]];
        n[2] = k[2] ^ SBOX[k[15]];
        n[3] = k[3] ^ SBOX[k[12]];
        for (int i = 4; i < 16; i++) begin
            n[i] = k[i] ^ n[i-4];
        end
        return n;
    endfunction

    // One AES round: SubBytes, ShiftRows, MixColumns unless last, AddRoundKey.
    function automatic rkacw_blk_t aes_round(input rkacw_blk_t s, input rkacw_blk_t k,
                                             input logic last);
        rkacw_blk_t t;
        rkacw_blk_t m;
        logic [7:0] all;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[r + 4*c] = SBOX[s[r + 4*((c + r) % 4)]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xt(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xt(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xt(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xt(t[4*c+3] ^ t[4*c]);
        end
        return (last ? t : m) ^ k;
    endfunction

    // Initial key built from a chain point.
    function automatic rkacw_blk_t point_key(input logic [23:0] p);
        rkacw_blk_t k;
        k = '0;
        k[0] = p[23:16];
        k[4] = p[15:8];
        k[8] = p[7:0];
        return k;
    endfunction

endpackage

FILE: design/rkacw_fifo.sv
// Small first-in first-out queue in flip-flops with a combinational head.
// Uses no package; instantiated by the front part and the back part.
module rkacw_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and count update with wrap at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end
endmodule

FILE: design/rkacw_front.sv
// Front part: queues incoming words, masks the fields and attaches the step count to each item.
// Depends on rkacw_pkg and rkacw_fifo.
module rkacw_front #(
    parameter int KEY_BITS = 24,
    parameter int TABLE_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [23:0]          start_point,
    input  logic [7:0]           table_index,
    input  logic [10:0]          chain_length,
    output rkacw_pkg::rkacw_item_t item,
    input  logic                 take
);
    import rkacw_pkg::*;

    localparam logic [31:0] KEY_MASK32 = (32'd1 << KEY_BITS) - 32'd1;
    localparam logic [31:0] TBL_MASK32 = (32'd1 << TABLE_BITS) - 32'd1;

    logic [31:0] head;
    logic        q_empty;

    // Fields are masked on the way in.
    rkacw_fifo #(.WIDTH(32), .DEPTH(IN_DEPTH)) u_in_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({start_point & KEY_MASK32[23:0], table_index & TBL_MASK32[7:0]}),
        .full    (full),
        .rd_en   (take),
        .rd_data (head),
        .empty   (q_empty)
    );

    // A chain length of zero or one takes no step.
    always_comb
    begin
        item.vld   = !q_empty;
        item.start = head[31:8];
        item.tbl   = head[7:0];
        item.steps = (chain_length == '0) ? '0 : chain_length - 11'd1;
    end
endmodule

FILE: design/rkacw_engine.sv
// Back part: ten-stage AES round pipeline that interleaves up to ten chains, plus the result queue.
// Depends on rkacw_pkg and rkacw_fifo.
module rkacw_engine #(
    parameter int KEY_BITS = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  rkacw_pkg::rkacw_blk_t   plaintext,
    input  rkacw_pkg::rkacw_item_t  item,
    output logic                    take,
    input  logic                    pop,
    output logic                    empty,
    output logic [23:0]             end_point,
    output logic [23:0]             start_echo,
    output rkacw_pkg::rkacw_status_t status
);
    import rkacw_pkg::*;

    localparam logic [31:0] KEY_MASK32 = (32'd1 << KEY_BITS) - 32'd1;

    logic        vld_reg   [NUM_ROUNDS];
    rkacw_blk_t  s_reg     [NUM_ROUNDS];
    rkacw_blk_t  k_reg     [NUM_ROUNDS];
    logic [23:0] start_reg [NUM_ROUNDS];
    logic [7:0]  tbl_reg   [NUM_ROUNDS];
    logic [10:0] rem_reg   [NUM_ROUNDS];

    logic [CREDIT_W-1:0] credit_reg, credit_next;

    rkacw_blk_t  last_key;
    rkacw_blk_t  ct;
    logic [23:0] new_point;
    logic        recirc;
    logic        retire;
    logic        has_credit;
    logic        insert;
    logic        bypass;
    logic [23:0] in_point;
    logic        ins_vld;
    logic [23:0] ins_start;
    logic [7:0]  ins_tbl;
    logic [10:0] ins_rem;
    logic        oq_push;
    logic [47:0] oq_data;
    logic [47:0] oq_head;
    logic        oq_full;
    logic        oq_pop;

    // Final round and reduction of the chain in the last stage.
    always_comb
    begin
        last_key  = next_key(k_reg[NUM_ROUNDS-1], RCON[NUM_ROUNDS-1]);
        ct        = aes_round(s_reg[NUM_ROUNDS-1], last_key, 1'b1);
        new_point = ({ct[0], ct[4], ct[8]} + {16'd0, tbl_reg[NUM_ROUNDS-1]})
                    & KEY_MASK32[23:0];
        recirc    = vld_reg[NUM_ROUNDS-1] && (rem_reg[NUM_ROUNDS-1] != 11'd1);
        retire    = vld_reg[NUM_ROUNDS-1] && (rem_reg[NUM_ROUNDS-1] == 11'd1);
    end

    // Dispatch: a new chain enters the free first slot; a stepless item goes straight out.
    always_comb
    begin
        has_credit = (credit_reg < CREDIT_W'(OUT_DEPTH));
        insert     = item.vld && has_credit && (item.steps != '0) && !recirc;
        bypass     = item.vld && has_credit && (item.steps == '0) && !retire;
        take       = insert || bypass;
    end

    // Input of the first slot: a recirculating chain wins over a new one.
    always_comb
    begin
        if (recirc)
        begin
            ins_vld   = 1'b1;
            in_point  = new_point;
            ins_start = start_reg[NUM_ROUNDS-1];
            ins_tbl   = tbl_reg[NUM_ROUNDS-1];
            ins_rem   = rem_reg[NUM_ROUNDS-1] - 11'd1;
        end
        else
        begin
            ins_vld   = insert;
            in_point  = item.start;
            ins_start = item.start;
            ins_tbl   = item.tbl;
            ins_rem   = item.steps;
        end
    end

    // Slot valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_ROUNDS; j++)
            begin
                vld_reg[j] <= 1'b0;
            end
            credit_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= ins_vld;
            for (int j = 1; j < NUM_ROUNDS; j++)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
            credit_reg <= credit_next;
        end
    end

    // Slot payload: the first stage adds the initial key and each later stage applies one AES round.
    always_ff @(posedge clk)
    begin
        s_reg[0]     <= plaintext ^ point_key(in_point);
        k_reg[0]     <= point_key(in_point);
        start_reg[0] <= ins_start;
        tbl_reg[0]   <= ins_tbl;
        rem_reg[0]   <= ins_rem;
        for (int j = 1; j < NUM_ROUNDS; j++)
        begin
            k_reg[j]     <= next_key(k_reg[j-1], RCON[j-1]);
            s_reg[j]     <= aes_round(s_reg[j-1], next_key(k_reg[j-1], RCON[j-1]), 1'b0);
            start_reg[j] <= start_reg[j-1];
            tbl_reg[j]   <= tbl_reg[j-1];
            rem_reg[j]   <= rem_reg[j-1];
        end
    end

    // Credits count items in the pipeline and the result queue.
    assign oq_pop      = pop && !empty;
    assign credit_next = credit_reg + CREDIT_W'(take) - CREDIT_W'(oq_pop);

    assign oq_push = retire || bypass;
    assign oq_data = retire ? {new_point, start_reg[NUM_ROUNDS-1]} : {item.start, item.start};

    rkacw_fifo #(.WIDTH(48), .DEPTH(OUT_DEPTH)) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (oq_push),
        .wr_data (oq_data),
        .full    (oq_full),
        .rd_en   (pop),
        .rd_data (oq_head),
        .empty   (empty)
    );

    assign end_point  = oq_head[47:24];
    assign start_echo = oq_head[23:0];

    always_comb
    begin
        status.retire = retire && !oq_full;
        status.bypass = bypass;
        status.credit = credit_reg;
    end
endmodule

FILE: design/reduced_key_aes_chain_walker_top.sv
// Top level of the reduced-key AES chain walker: configuration registers, front and back parts.
// Depends on rkacw_pkg, rkacw_front and rkacw_engine.
//
// Channel   Handshake             Word
// input     push / full           start_point, table_index
// result    empty / pop           end_point, start_echo
// config    cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each chain step is one AES-128 encryption through a ten-stage round pipeline; an item
// runs chain_length - 1 steps and enters the pipeline from the input queue when the first
// stage is free.
// Up to ten chains share the pipeline, one per stage; a chain length of zero or one sends the
// item straight to the result queue.
// Reset clears all control state and loads the register defaults; no clearing pass is needed.
// Configuration writes are always ready. A stalled result side fills the 16-entry result queue,
// after which new chains wait in the input queue.
module reduced_key_aes_chain_walker_top #(
    parameter int KEY_BITS = 24,
    parameter int TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] start_point,
    input  logic [7:0]  table_index,
    output logic        empty,
    input  logic        pop,
    output logic [23:0] end_point,
    output logic [23:0] start_echo,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import rkacw_pkg::*;

    logic [31:0]   pt_reg [4];
    logic [10:0]   chain_len_reg;
    rkacw_blk_t    plaintext;
    rkacw_item_t   item;
    logic          take;
    rkacw_status_t status;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_reg[0]     <= PT_WORD0_RST;
            pt_reg[1]     <= PT_WORD1_RST;
            pt_reg[2]     <= PT_WORD2_RST;
            pt_reg[3]     <= PT_WORD3_RST;
            chain_len_reg <= CHAIN_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PT_WORD0:  pt_reg[0] <= cfg_data;
                REG_PT_WORD1:  pt_reg[1] <= cfg_data;
                REG_PT_WORD2:  pt_reg[2] <= cfg_data;
                REG_PT_WORD3:  pt_reg[3] <= cfg_data;
                REG_CHAIN_LEN: chain_len_reg <= cfg_data[10:0];
                default:       ;
            endcase
        end
    end

    // Plaintext bytes, first byte of each word in its top bits.
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            plaintext[i] = pt_reg[i / 4][(31 - 8 * (i % 4)) -: 8];
        end
    end

    rkacw_front #(.KEY_BITS(KEY_BITS), .TABLE_BITS(TABLE_BITS)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .start_point  (start_point),
        .table_index  (table_index),
        .chain_length (chain_len_reg),
        .item         (item),
        .take         (take)
    );

    rkacw_engine #(.KEY_BITS(KEY_BITS)) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .plaintext  (plaintext),
        .item       (item),
        .take       (take),
        .pop        (pop),
        .empty      (empty),
        .end_point  (end_point),
        .start_echo (start_echo),
        .status     (status)
    );

`ifndef SYNTHESIS
    // The credit count never exceeds the result queue depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.credit <= CREDIT_W'(OUT_DEPTH))
        else $error("credit count above result queue depth");

    // A retiring chain and a stepless item never compete for the result queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(status.retire && status.bypass))
        else $error("retire and bypass in the same cycle");

    // With no credit in use, the result queue is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (status.credit == '0) |-> empty)
        else $error("result waiting without credit");
`endif
endmodule
